>>> rtl/icmpu_pkg.sv
`default_nettype none

package icmpu_pkg;

	// Status table geometry
	localparam int TABLE_PORTS = 1024;
	localparam int TBL_AW = $clog2(TABLE_PORTS);

	// Frame layout
	localparam logic [7:0] ETH_BYTES      = 8'd14;
	localparam logic [7:0] ICMP_HDR_BYTES = 8'd8;
	localparam logic [7:0] INNER_DST_AT   = 8'd16;
	localparam logic [7:0] UDP_DPORT_AT   = 8'd2;
	localparam logic [7:0] ICMP_UNREACH   = 8'd3;
	localparam logic [7:0] PORT_UNREACH   = 8'd3;
	localparam logic [7:0] IHL_MASK       = 8'h0f;
	localparam logic [5:0] MIN_IP_BYTES   = 6'd20;

	// Configuration register indexes
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] REG_TARGET_IP  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_START_PORT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_PORT_COUNT = 2'd2;
	localparam logic [10:0] PORT_COUNT_RESET = 11'd1024;

	// Operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Reply kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Verdicts
	localparam logic [1:0] VERDICT_IGNORED   = 2'd0;
	localparam logic [1:0] VERDICT_CLOSED    = 2'd1;
	localparam logic [1:0] VERDICT_UNKNOWN   = 2'd2;
	localparam logic [1:0] VERDICT_OUT_RANGE = 2'd3;

	// Port status
	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_OPEN    = 2'd1;
	localparam logic [1:0] ST_CLOSED  = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [9:0] read_index;
	} item_t;

	typedef struct packed {
		logic        reply_kind;
		logic [1:0]  verdict;
		logic [15:0] port_offset;
		logic [1:0]  port_status;
		logic [15:0] answered_count;
		logic        all_answered;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/icmp_port_unreachable_classifier.sv
`default_nettype none

// Channel   Direction  Handshake                    Word
// item      in         item_valid / item_ready      icmpu_pkg::item_t
// result    out        result_valid / result_ready  icmpu_pkg::result_t
// config    in         cfg_we (no wait)             cfg_index, cfg_data
//
// One word is accepted per cycle while item_ready is high; frame bytes that are not the
// last byte of a frame give no result. A last byte or a read gives one result, registered
// first in stage s1 (for the table read) and then in the output register.
// After reset a clearing pass writes every status table entry to unknown, one per cycle;
// item_ready stays low during it, while config writes still land.
// A stalled result holds stage s1 and then item_ready; frame bytes keep flowing as long
// as stage s1 is free to advance.
module icmp_port_unreachable_classifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire icmpu_pkg::item_t               item,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output icmpu_pkg::result_t                  result,
	input  wire logic                           cfg_we,
	input  wire logic [icmpu_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	localparam int AW = icmpu_pkg::TBL_AW;

	// Configuration
	logic [31:0] target_ip_q;
	logic [15:0] start_port_q;
	logic [10:0] port_count_q;

	// Per-frame parse state
	logic [7:0]  pos_q;
	logic [5:0]  ohb_q;
	logic [5:0]  ihb_q;
	logic        code3_q;
	logic [31:0] addr_q;
	logic [15:0] rport_q;
	logic        drop_q;

	logic [5:0]  ohb_n;
	logic [5:0]  ihb_n;
	logic        code3_n;
	logic [31:0] addr_n;
	logic [15:0] rport_n;
	logic        drop_n;

	logic [7:0]  icmp_at;
	logic [7:0]  inner_at;
	logic [7:0]  udp_at;
	logic [7:0]  udp_end_n;
	logic [7:0]  hdr_mask;
	logic [5:0]  hdr_len;
	logic        hit_n;

	// Stage s1
	logic            valid_s1;
	logic            kind_s1;
	logic            hit_s1;
	logic            code3_s1;
	logic [15:0]     rport_s1;
	logic [9:0]      ridx_s1;
	logic            rd_inrange_s1;
	logic            fwd_s1;
	logic [1:0]      fwd_st_s1;

	logic [15:0]     offset;
	logic            in_range;
	logic            wr;
	logic            wr_go;
	logic [1:0]      status_w;
	logic [15:0]     cnt_n;
	logic            go_s1;
	icmpu_pkg::result_t res_c;

	// Output register and counter
	logic               res_valid_q;
	icmpu_pkg::result_t res_q;
	logic [15:0]        cnt_q;

	// Status table
	logic [1:0]    table_mem [icmpu_pkg::TABLE_PORTS];
	logic [1:0]    rdata_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [1:0]    mem_wd;
	logic [AW-1:0] rd_addr;
	logic          rd_en;

	logic accept;
	logic accept_byte;
	logic to_s1;

	assign accept      = item_valid && item_ready;
	assign accept_byte = accept && (item.operation == icmpu_pkg::OP_BYTE);
	assign rd_en       = accept && (item.operation == icmpu_pkg::OP_READ);
	assign to_s1       = accept && ((item.operation == icmpu_pkg::OP_READ) || item.last_byte);
	assign rd_addr     = AW'(item.read_index);

	// Config writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_ip_q  <= '0;
			start_port_q <= '0;
			port_count_q <= icmpu_pkg::PORT_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				icmpu_pkg::REG_TARGET_IP:  target_ip_q  <= cfg_data;
				icmpu_pkg::REG_START_PORT: start_port_q <= cfg_data[15:0];
				icmpu_pkg::REG_PORT_COUNT: port_count_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Parse one frame byte against the current position. Header offsets follow
	// from the two IHL fields, so each field position is a compare on pos_q.
	always_comb begin
		ohb_n    = ohb_q;
		ihb_n    = ihb_q;
		code3_n  = code3_q;
		addr_n   = addr_q;
		rport_n  = rport_q;
		drop_n   = drop_q;
		hdr_mask = item.data_byte & icmpu_pkg::IHL_MASK;
		hdr_len  = {hdr_mask[3:0], 2'b00};
		icmp_at  = icmpu_pkg::ETH_BYTES + {2'b00, ohb_q};
		inner_at = icmp_at + icmpu_pkg::ICMP_HDR_BYTES;
		udp_at   = inner_at + {2'b00, ihb_q};
		if (!drop_q) begin
			if (pos_q == icmpu_pkg::ETH_BYTES) begin
				ohb_n = hdr_len;
				if (hdr_len < icmpu_pkg::MIN_IP_BYTES)
					drop_n = 1'b1;
			end else if (pos_q > icmpu_pkg::ETH_BYTES && ohb_q >= icmpu_pkg::MIN_IP_BYTES) begin
				if (pos_q == icmp_at) begin
					if (item.data_byte != icmpu_pkg::ICMP_UNREACH)
						drop_n = 1'b1;
				end else if (pos_q == icmp_at + 8'd1) begin
					code3_n = (item.data_byte == icmpu_pkg::PORT_UNREACH);
				end else if (pos_q == inner_at) begin
					ihb_n = hdr_len;
					if (hdr_len < icmpu_pkg::MIN_IP_BYTES)
						drop_n = 1'b1;
				end else if (pos_q > inner_at && ihb_q >= icmpu_pkg::MIN_IP_BYTES) begin
					if (pos_q >= inner_at + icmpu_pkg::INNER_DST_AT &&
					    pos_q <= inner_at + icmpu_pkg::INNER_DST_AT + 8'd3) begin
						addr_n = {addr_q[23:0], item.data_byte};
					end else if (pos_q == udp_at + icmpu_pkg::UDP_DPORT_AT ||
					             pos_q == udp_at + icmpu_pkg::UDP_DPORT_AT + 8'd1) begin
						rport_n = {rport_q[7:0], item.data_byte};
					end
				end
			end
		end
		// The frame counts only once the whole destination port has gone by.
		udp_end_n = icmpu_pkg::ETH_BYTES + {2'b00, ohb_n} + icmpu_pkg::ICMP_HDR_BYTES +
		            {2'b00, ihb_n} + icmpu_pkg::UDP_DPORT_AT + 8'd1;
		hit_n = !drop_n && ohb_n >= icmpu_pkg::MIN_IP_BYTES &&
		        ihb_n >= icmpu_pkg::MIN_IP_BYTES && pos_q >= udp_end_n &&
		        addr_n == target_ip_q;
	end

	// Advance the parse state; clear it after the last byte of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ohb_q   <= '0;
			ihb_q   <= '0;
			code3_q <= 1'b0;
			addr_q  <= '0;
			rport_q <= '0;
			drop_q  <= 1'b0;
		end else if (accept_byte) begin
			if (item.last_byte) begin
				pos_q   <= '0;
				ohb_q   <= '0;
				ihb_q   <= '0;
				code3_q <= 1'b0;
				addr_q  <= '0;
				rport_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				pos_q   <= (pos_q == 8'hff) ? pos_q : pos_q + 8'd1;
				ohb_q   <= ohb_n;
				ihb_q   <= ihb_n;
				code3_q <= code3_n;
				addr_q  <= addr_n;
				rport_q <= rport_n;
				drop_q  <= drop_n;
			end
		end
	end

	// Stage s1: words that give a result. A read issued in the same cycle as a
	// table write to the same entry takes the written value instead of the RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (to_s1) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (to_s1) begin
			kind_s1       <= item.operation;
			hit_s1        <= hit_n;
			code3_s1      <= code3_n;
			rport_s1      <= rport_n;
			ridx_s1       <= item.read_index;
			rd_inrange_s1 <= 17'(item.read_index) < 17'(icmpu_pkg::TABLE_PORTS);
			fwd_s1        <= wr_go && (mem_wa == rd_addr);
			fwd_st_s1     <= status_w;
		end
	end

	always_comb begin
		offset   = rport_s1 - start_port_q;
		in_range = (offset < {5'b0, port_count_q}) &&
		           (17'(offset) < 17'(icmpu_pkg::TABLE_PORTS));
		status_w = code3_s1 ? icmpu_pkg::ST_CLOSED : icmpu_pkg::ST_UNKNOWN;
		wr       = valid_s1 && (kind_s1 == icmpu_pkg::OP_BYTE) && hit_s1 && in_range;
		cnt_n    = (wr && cnt_q != 16'hffff) ? cnt_q + 16'd1 : cnt_q;

		res_c.reply_kind     = icmpu_pkg::KIND_FRAME;
		res_c.verdict        = icmpu_pkg::VERDICT_IGNORED;
		res_c.port_offset    = '0;
		res_c.port_status    = icmpu_pkg::ST_UNKNOWN;
		res_c.answered_count = cnt_n;
		res_c.all_answered   = cnt_n >= {5'b0, port_count_q};
		if (kind_s1 == icmpu_pkg::OP_READ) begin
			res_c.reply_kind  = icmpu_pkg::KIND_READ;
			res_c.port_offset = {6'b0, ridx_s1};
			if (rd_inrange_s1)
				res_c.port_status = fwd_s1 ? fwd_st_s1 : rdata_q;
		end else if (hit_s1) begin
			res_c.port_offset = offset;
			if (in_range) begin
				res_c.verdict     = code3_s1 ? icmpu_pkg::VERDICT_CLOSED
				                             : icmpu_pkg::VERDICT_UNKNOWN;
				res_c.port_status = status_w;
			end else begin
				res_c.verdict = icmpu_pkg::VERDICT_OUT_RANGE;
			end
		end
	end

	assign go_s1      = valid_s1 && (!res_valid_q || result_ready);
	assign wr_go      = go_s1 && wr;
	assign item_ready = !clr_q && (!valid_s1 || go_s1);

	// Output register and answered counter; both move when s1 retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (go_s1) begin
				res_valid_q <= 1'b1;
				cnt_q       <= cnt_n;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1)
			res_q <= res_c;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Clearing pass: sweep every entry to unknown after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(icmpu_pkg::TABLE_PORTS - 1))
				clr_q <= 1'b0;
		end
	end

	assign mem_we = clr_q || wr_go;
	assign mem_wa = clr_q ? clr_addr_q : AW'(offset);
	assign mem_wd = clr_q ? icmpu_pkg::ST_UNKNOWN : status_w;

	// Status table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we)
			table_mem[mem_wa] <= mem_wd;
		if (rd_en)
			rdata_q <= table_mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/icmpu_checker.sv
`default_nettype none

module icmpu_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire icmpu_pkg::result_t result
);

	// Hold a stalled result word.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// A read reply carries no verdict.
	a_read_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.reply_kind == icmpu_pkg::KIND_READ |->
		result.verdict == icmpu_pkg::VERDICT_IGNORED)
		else $error("read reply with a verdict");

	// An ignored frame reports no port and no status.
	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.reply_kind == icmpu_pkg::KIND_FRAME &&
		result.verdict == icmpu_pkg::VERDICT_IGNORED |->
		result.port_offset == 16'd0 && result.port_status == icmpu_pkg::ST_UNKNOWN)
		else $error("ignored frame with port data");

	// The status reported for a frame agrees with its verdict.
	a_status_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.reply_kind == icmpu_pkg::KIND_FRAME |->
		(result.verdict == icmpu_pkg::VERDICT_CLOSED) ==
		(result.port_status == icmpu_pkg::ST_CLOSED))
		else $error("frame status disagrees with verdict");

endmodule

bind icmp_port_unreachable_classifier icmpu_checker u_icmpu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
